// ===== hw/rtl/scancode_line_buffer_top_assert.svh =====
// Assertion macros for the checker file.
`ifndef SCANCODE_LINE_BUFFER_TOP_ASSERT_SVH
`define SCANCODE_LINE_BUFFER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SCB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scb assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SCB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scb assertion failed");

`endif

// ===== hw/rtl/scb_pkg.sv =====
`default_nettype none
package scb_pkg;

    typedef logic [6:0] t_char;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        MODE_KEY   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    localparam logic [7:0] SC_REL_BIT = 8'h80;
    localparam logic [6:0] SC_CODE_MASK = 7'h7F;
    localparam logic [6:0] SC_LSHIFT = 7'h2A;
    localparam logic [6:0] SC_RSHIFT = 7'h36;
    localparam logic [6:0] SC_CAPS   = 7'h3A;
    localparam logic [6:0] SC_CTRL   = 7'h1D;
    localparam logic [6:0] SC_ALT    = 7'h38;
    localparam logic [6:0] SC_BKSP   = 7'h0E;
    localparam logic [6:0] SC_ENTER  = 7'h1C;
    localparam t_char      CH_NEWLINE = 7'h0A;
    localparam int         MapLen = 59;

    localparam t_char PLAIN_MAP [MapLen] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
        7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
        7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
        7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

    localparam t_char UPPER_MAP [MapLen] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
        7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
        7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
        7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

    // What one scancode does to the line state
    typedef struct packed {
        logic  set_shift;
        logic  clr_shift;
        logic  set_ctrl;
        logic  clr_ctrl;
        logic  set_alt;
        logic  clr_alt;
        logic  tog_caps;
        logic  bksp;
        logic  push;
        t_char ch;
    } t_key_act;

endpackage
`default_nettype wire

// ===== hw/rtl/scb_keymap.sv =====
`default_nettype none
// Scancode decode and table lookup.
module scb_keymap
    import scb_pkg::*;
(
    input  wire logic [7:0] i_scancode,
    input  wire logic       i_upper,
    output t_key_act        o_act
);

    logic [6:0] code;
    logic       in_map;
    t_char      plain_ch;
    t_char      upper_ch;

    assign code     = i_scancode[6:0] & SC_CODE_MASK;
    assign in_map   = (i_scancode < 8'(MapLen));
    assign plain_ch = in_map ? PLAIN_MAP[i_scancode[5:0]] : '0;
    assign upper_ch = in_map ? UPPER_MAP[i_scancode[5:0]] : '0;

    always_comb begin
        o_act = '0;
        if ((i_scancode & SC_REL_BIT) != 8'h00) begin
            // release: only modifiers care
            if (code == SC_LSHIFT || code == SC_RSHIFT) begin
                o_act.clr_shift = 1'b1;
            end else if (code == SC_CTRL) begin
                o_act.clr_ctrl = 1'b1;
            end else if (code == SC_ALT) begin
                o_act.clr_alt = 1'b1;
            end
        end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
            o_act.set_shift = 1'b1;
        end else if (code == SC_CAPS) begin
            o_act.tog_caps = 1'b1;
        end else if (code == SC_CTRL) begin
            o_act.set_ctrl = 1'b1;
        end else if (code == SC_ALT) begin
            o_act.set_alt = 1'b1;
        end else if (code == SC_BKSP) begin
            o_act.bksp = 1'b1;
        end else if (code == SC_ENTER) begin
            o_act.push = 1'b1;
            o_act.ch   = CH_NEWLINE;
        end else if (plain_ch != '0) begin
            o_act.push = 1'b1;
            o_act.ch   = i_upper ? upper_ch : plain_ch;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/scancode_line_buffer_top.sv =====
`default_nettype none
// Keyboard line buffer: takes set-1 scancodes, read requests and clear
// requests on the slave stream and returns one result per item on the
// master stream. Key presses are translated to ASCII (shift or caps lock
// selects the shifted table) and appended to a ring of BUFFER_DEPTH entries
// that holds up to BUFFER_DEPTH-1 characters; keys are dropped when it is
// full. Backspace drops the newest character, a read pops the oldest (0 when
// empty), a clear empties the ring but keeps the modifier flags. Mode 3 is
// ignored. One item is taken per cycle unless a result waits on a stalled
// master; each result appears the cycle after its transfer (registered read).
// The ring needs no clearing pass after reset: only written entries are read.
// While a result waits on a stalled master, the next item is held off.
module scancode_line_buffer_top
    import scb_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] scancode
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [6:0] read_char, [14:7] buffered_count, [15] shift_held,
    // [16] caps_on, [17] ctrl_held, [18] alt_held, [23:19] zero
    output logic [23:0]      m_axis_tdata
);

    localparam int PW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [PW:0]   DepthW = (PW + 1)'(BUFFER_DEPTH);
    localparam logic [PW-1:0] FullCount = PW'(BUFFER_DEPTH - 1);

    // ring state
    logic [PW-1:0] r_oldest, n_oldest;
    logic [PW-1:0] r_count,  n_count;
    logic          r_shift,  n_shift;
    logic          r_caps,   n_caps;
    logic          r_ctrl,   n_ctrl;
    logic          r_alt,    n_alt;

    // result stage
    logic          r_out_valid;
    logic          r_out_pop, n_out_pop;

    // character memory, registered read
    t_char         r_mem [BUFFER_DEPTH];
    t_char         r_rd_data;

    logic          accept;
    t_mode         mode;
    t_key_act      act;
    logic          wr_en;
    logic          rd_en;
    logic [PW:0]   tail_sum;
    logic [PW-1:0] tail_pos;
    logic [PW:0]   next_sum;
    logic [PW-1:0] next_oldest;
    logic [PW+7:0] count_ext;

    // stage advances when empty or when its result is taken
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mode          = t_mode'(s_axis_tuser);

    scb_keymap u_keymap (
        .i_scancode (s_axis_tdata),
        .i_upper    (r_shift || r_caps),
        .o_act      (act)
    );

    // (oldest + count) mod depth; sum stays below twice the depth
    assign tail_sum = {1'b0, r_oldest} + {1'b0, r_count};
    assign tail_pos = (tail_sum >= DepthW) ? PW'(tail_sum - DepthW) : tail_sum[PW-1:0];
    assign next_sum = {1'b0, r_oldest} + (PW + 1)'(1);
    assign next_oldest = (next_sum >= DepthW) ? PW'(next_sum - DepthW) : next_sum[PW-1:0];

    always_comb begin
        n_oldest  = r_oldest;
        n_count   = r_count;
        n_shift   = r_shift;
        n_caps    = r_caps;
        n_ctrl    = r_ctrl;
        n_alt     = r_alt;
        n_out_pop = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        if (accept) begin
            case (mode)
                MODE_KEY: begin
                    if (act.set_shift) n_shift = 1'b1;
                    if (act.clr_shift) n_shift = 1'b0;
                    if (act.set_ctrl)  n_ctrl  = 1'b1;
                    if (act.clr_ctrl)  n_ctrl  = 1'b0;
                    if (act.set_alt)   n_alt   = 1'b1;
                    if (act.clr_alt)   n_alt   = 1'b0;
                    if (act.tog_caps)  n_caps  = !r_caps;
                    if (act.bksp && r_count != '0) begin
                        n_count = r_count - PW'(1);
                    end
                    if (act.push && r_count != FullCount) begin
                        wr_en   = 1'b1;
                        n_count = r_count + PW'(1);
                    end
                end
                MODE_READ: begin
                    if (r_count != '0) begin
                        rd_en     = 1'b1;
                        n_out_pop = 1'b1;
                        n_oldest  = next_oldest;
                        n_count   = r_count - PW'(1);
                    end
                end
                MODE_CLEAR: begin
                    n_oldest = '0;
                    n_count  = '0;
                end
                default: begin
                    // unused mode: state unchanged
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest    <= '0;
            r_count     <= '0;
            r_shift     <= 1'b0;
            r_caps      <= 1'b0;
            r_ctrl      <= 1'b0;
            r_alt       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_pop   <= 1'b0;
        end else begin
            r_oldest <= n_oldest;
            r_count  <= n_count;
            r_shift  <= n_shift;
            r_caps   <= n_caps;
            r_ctrl   <= n_ctrl;
            r_alt    <= n_alt;
            if (accept) begin
                r_out_valid <= 1'b1;
                r_out_pop   <= n_out_pop;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // write at the tail, read the head; a read never targets the entry
    // written in the same transfer (a pop needs a nonzero count)
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[tail_pos] <= act.ch;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_oldest];
        end
    end

    // state registers only move on a transfer, so they double as the
    // result's held fields while the master stalls
    assign count_ext     = {8'h00, r_count};
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0_0000, r_alt, r_ctrl, r_caps, r_shift,
                            count_ext[7:0], (r_out_pop ? r_rd_data : t_char'(0))};

endmodule
`default_nettype wire

// ===== hw/rtl/scb_checker.sv =====
`default_nettype none
`include "scancode_line_buffer_top_assert.svh"
// Port-level checks on the line buffer.
module scb_checker
    import scb_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);

    logic in_xfer;
    logic clr_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign clr_xfer = in_xfer && (s_axis_tuser == MODE_CLEAR);

    // stalled result holds
    `SCB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))
    // every input transfer yields a result next cycle
    `SCB_ASSERT_NEXT(a_in_to_out, i_clk, i_rst_n, in_xfer, m_axis_tvalid)
    // a clear reports an empty ring and no character
    `SCB_ASSERT_NEXT(a_clear_empty, i_clk, i_rst_n, clr_xfer,
                     m_axis_tdata[14:0] == 15'h0000)

endmodule

bind scancode_line_buffer_top scb_checker u_scb_checker (.*);
`default_nettype wire
